### sv/mf2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_pkg: shared types and constants for the 2-D median filter
// Holds the request action codes, the register indices and the compare-exchange cell control struct.
// ----------------------------------------------------------------------------
package mf2d_pkg;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	typedef struct packed {
		logic clr;    // fill every cell with all-ones
		logic shift;  // shift the chain up by one, new sample enters cell 0
		logic run;    // compare-exchange with the neighbor of this phase
		logic odd;    // phase of odd-even transposition
	} cell_ctrl_t;

endpackage

### sv/mf2d_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_cell: one compare-exchange slot of the sorting chain
// Holds one sample; each cycle it clears, shifts, swaps with a neighbor or holds.
// ----------------------------------------------------------------------------
module mf2d_cell #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  mf2d_pkg::cell_ctrl_t  ctrl,
	input  logic                  pair_up,
	input  logic                  pair_dn,
	input  logic [PIXEL_BITS-1:0] up_val,
	input  logic [PIXEL_BITS-1:0] dn_val,
	output logic [PIXEL_BITS-1:0] val_q
);
	logic [PIXEL_BITS-1:0] nxt;

	always_comb begin
		nxt = val_q;
		if (ctrl.clr) begin
			nxt = '1;
		end else if (ctrl.shift) begin
			nxt = dn_val;
		end else if (ctrl.run && pair_up) begin
			// lower slot of the pair keeps the minimum
			nxt = (up_val < val_q) ? up_val : val_q;
		end else if (ctrl.run && pair_dn) begin
			nxt = (dn_val > val_q) ? dn_val : val_q;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= nxt;
	end
endmodule

### sv/mf2d_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_sort: chain of compare-exchange cells (odd-even transposition sort)
// Samples shift in at cell 0; N passes sort the chain in ascending order.
// Slots left over from the clear hold all-ones and sink to the top.
// ----------------------------------------------------------------------------
module mf2d_sort #(
	parameter int PIXEL_BITS = 16,
	parameter int N = 49
) (
	input  logic                         clk,
	input  mf2d_pkg::cell_ctrl_t         ctrl,
	input  logic [PIXEL_BITS-1:0]        shift_in,
	output logic [N-1:0][PIXEL_BITS-1:0] vals
);
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic pair_up, pair_dn;
		logic [PIXEL_BITS-1:0] up_v, dn_v, v_q;
		// cell i pairs with i+1 when the parity of i matches the phase
		if (i + 1 < N) begin : g_up
			assign up_v = vals[i+1];
			assign pair_up = (((i % 2) == 1) == ctrl.odd);
		end else begin : g_top
			assign up_v = v_q;
			assign pair_up = 1'b0;
		end
		if (i > 0) begin : g_dn
			assign dn_v = vals[i-1];
			assign pair_dn = ((((i - 1) % 2) == 1) == ctrl.odd);
		end else begin : g_bot
			assign dn_v = shift_in;
			assign pair_dn = 1'b0;
		end
		mf2d_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
			.clk(clk), .ctrl(ctrl), .pair_up(pair_up), .pair_dn(pair_dn),
			.up_val(up_v), .dn_val(dn_v), .val_q(v_q));
		assign vals[i] = v_q;
	end
endmodule

### sv/median_filter_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_2d_top: streaming two-dimensional median filter
// Raster-order pixels in, median over in-bounds square window out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, action, pixel_value): a pixel request
//   writes the line buffer; a drain request writes nothing and only flushes
//   a pending output. Output channel (out_valid/out_stall,
//   filtered_value, frame_last) carries at most one result per request.
//   Each request is handled one at a time: accept, a check state,
//   a window gather of one pixel per cycle (K pixels, K up to
//   MAX_WINDOW^2, set by the single read port of the line buffer), NCELL+1
//   compare-exchange passes in the cell chain, then a pick state that loads
//   the output register. A request without a result goes from the check
//   state back to idle.
//   The result sits in an output register; the next request is taken while
//   it waits, but a new result is only produced once it has been taken.
//   Reset clears positions, registers to 640/480/3, and the output channel.
//   Line buffer contents are undefined until written; only written rows are
//   ever read. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
module median_filter_2d_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 7,
	parameter int PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] pixel_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] filtered_value,
	output logic        frame_last
);
	localparam int HALF  = MAX_WINDOW / 2;
	localparam int ROWS  = 2 * HALF + 2;
	localparam int SIDE  = 2 * HALF + 1;
	localparam int NCELL = SIDE * SIDE;
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(ROWS);
	localparam int DEPTH = ROWS * (2 ** XW);
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(NCELL + 1);
	localparam int HW    = $clog2(HALF + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_GATHER, ST_SORT, ST_PICK, ST_OUT} st_t;
	st_t st_q;

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  win_q;
	logic [16:0] in_row_q, out_row_q;
	logic [CW-1:0] in_col_q, out_col_q;
	// line-buffer row slot of each row counter
	logic [RW-1:0] in_slot_q, out_slot_q, rr_slot_q;

	// effective config
	logic [CW-1:0] w_eff;
	logic [16:0]   h_eff;
	logic [HW-1:0] b_eff;
	always_comb begin
		if (width_q == 11'd0) w_eff = CW'(1);
		else if ({21'd0, width_q} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		h_eff = (height_q == 16'd0) ? 17'd1 : {1'b0, height_q};
		b_eff = ((32'(win_q) - 32'd1) / 2 > 32'(HALF) || win_q == 3'd0) ?
			((win_q == 3'd0) ? HW'(0) : HW'(HALF)) : HW'((win_q - 3'd1) >> 1);
	end

	assign pready = 1'b1;
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		case (paddr[3:2])
			mf2d_pkg::REG_WIDTH:  prdata = {21'd0, width_q};
			mf2d_pkg::REG_HEIGHT: prdata = {16'd0, height_q};
			mf2d_pkg::REG_WINDOW: prdata = {29'd0, win_q};
			default:              prdata = 32'd0;
		endcase
	end

	// line buffer
	logic [PIXEL_BITS-1:0] mem [DEPTH];
	logic [AW-1:0] rd_addr;
	logic [PIXEL_BITS-1:0] rd_data_q;
	logic mem_we;
	logic [AW-1:0] wr_addr;
	logic [PIXEL_BITS-1:0] wr_data;
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// window bounds
	logic [16:0] r1_q, rr_q;
	logic [CW-1:0] c0_q, c1_q, cc_q;
	logic [NW-1:0] n_q;
	logic gvalid_q;
	logic [NW-1:0] wptr_q;
	logic [NCELL-1:0][PIXEL_BITS-1:0] sorted;
	logic [NW-1:0] pass_q;
	mf2d_pkg::cell_ctrl_t ctrl;
	logic ready_out;
	logic [16:0] need_r;
	logic [CW-1:0] need_c;
	logic [RW-1:0] r0_slot;

	always_comb begin
		need_r = (out_row_q + 17'(b_eff) < h_eff) ? out_row_q + 17'(b_eff) : h_eff - 17'd1;
		need_c = (out_col_q + CW'(b_eff) < w_eff) ? out_col_q + CW'(b_eff) : w_eff - CW'(1);
		ready_out = (out_row_q < h_eff) &&
			((in_row_q > need_r) || (in_row_q == need_r && in_col_q > need_c));
		// slot of the window's first row; row 0 when the window is clipped at the top
		if (out_row_q < 17'(b_eff)) r0_slot = '0;
		else if (out_slot_q >= RW'(b_eff)) r0_slot = out_slot_q - RW'(b_eff);
		else r0_slot = out_slot_q + RW'(ROWS) - RW'(b_eff);
		rd_addr = AW'({rr_slot_q, cc_q[XW-1:0]});
		wr_addr = AW'({in_slot_q, in_col_q[XW-1:0]});
		wr_data = pixel_value[PIXEL_BITS-1:0];
		mem_we = (st_q == ST_IDLE) && in_valid && !in_stall &&
			action == mf2d_pkg::ACT_PIXEL && in_row_q < h_eff;
		ctrl.clr = (st_q == ST_CHECK) && ready_out;
		ctrl.shift = (st_q == ST_GATHER) && gvalid_q;
		ctrl.run = (st_q == ST_SORT);
		ctrl.odd = pass_q[0];
	end

	mf2d_sort #(.PIXEL_BITS(PIXEL_BITS), .N(NCELL)) u_sort (
		.clk(clk), .ctrl(ctrl), .shift_in(rd_data_q), .vals(sorted));

	assign in_stall = (st_q != ST_IDLE) || cfg_wr;

	logic [PIXEL_BITS:0] avg;
	assign avg = ({1'b0, sorted[n_q/2 - NW'(1)]} + {1'b0, sorted[n_q/2]}) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			width_q <= 11'd640; height_q <= 16'd480; win_q <= 3'd3;
			in_row_q <= '0; in_col_q <= '0; out_row_q <= '0; out_col_q <= '0;
			in_slot_q <= '0; out_slot_q <= '0; rr_slot_q <= '0;
			out_valid <= 1'b0; gvalid_q <= 1'b0; pass_q <= '0; wptr_q <= '0;
			n_q <= '0; r1_q <= '0; rr_q <= '0;
			c0_q <= '0; c1_q <= '0; cc_q <= '0; frame_last <= 1'b0;
			filtered_value <= '0;
		end else begin
			// drop the result once the receiver takes it
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_wr) begin
				case (paddr[3:2])
					mf2d_pkg::REG_WIDTH:  width_q <= pwdata[10:0];
					mf2d_pkg::REG_HEIGHT: height_q <= pwdata[15:0];
					mf2d_pkg::REG_WINDOW: win_q <= pwdata[2:0];
					default: ;
				endcase
				if (paddr[3:2] == mf2d_pkg::REG_WIDTH || paddr[3:2] == mf2d_pkg::REG_HEIGHT ||
					paddr[3:2] == mf2d_pkg::REG_WINDOW) begin
					in_row_q <= '0; in_col_q <= '0; out_row_q <= '0; out_col_q <= '0;
					in_slot_q <= '0; out_slot_q <= '0;
					st_q <= ST_IDLE;
				end
			end else begin
				case (st_q)
					ST_IDLE: if (in_valid) begin
						if (mem_we) begin
							if (in_col_q + CW'(1) >= w_eff) begin
								in_col_q <= '0; in_row_q <= in_row_q + 17'd1;
								in_slot_q <= (in_slot_q == RW'(ROWS - 1)) ? '0 : in_slot_q + RW'(1);
							end else in_col_q <= in_col_q + CW'(1);
						end
						st_q <= ST_CHECK;
					end
					ST_CHECK: begin
						if (ready_out) begin
							r1_q <= need_r;
							rr_q <= (out_row_q >= 17'(b_eff)) ? out_row_q - 17'(b_eff) : '0;
							rr_slot_q <= r0_slot;
							c0_q <= (out_col_q >= CW'(b_eff)) ? out_col_q - CW'(b_eff) : '0;
							cc_q <= (out_col_q >= CW'(b_eff)) ? out_col_q - CW'(b_eff) : '0;
							c1_q <= need_c;
							wptr_q <= '0; gvalid_q <= 1'b0;
							st_q <= ST_GATHER;
						end else st_q <= ST_IDLE;
					end
					ST_GATHER: begin
						// one read per cycle; the read data is registered and shifts in the cycle after
						if (gvalid_q) wptr_q <= wptr_q + NW'(1);
						if (rr_q > r1_q) begin
							gvalid_q <= 1'b0;
							if (!gvalid_q) begin
								n_q <= wptr_q; pass_q <= '0; st_q <= ST_SORT;
							end
						end else begin
							gvalid_q <= 1'b1;
							if (cc_q == c1_q) begin
								cc_q <= c0_q; rr_q <= rr_q + 17'd1;
								rr_slot_q <= (rr_slot_q == RW'(ROWS - 1)) ? '0 : rr_slot_q + RW'(1);
							end else cc_q <= cc_q + CW'(1);
						end
					end
					ST_SORT: begin
						pass_q <= pass_q + NW'(1);
						if (pass_q == NW'(NCELL)) st_q <= ST_PICK;
					end
					ST_PICK: if (!out_valid || !out_stall) begin
						filtered_value <= 16'(n_q[0] ? sorted[n_q/2] : avg[PIXEL_BITS-1:0]);
						frame_last <= (out_row_q == h_eff - 17'd1) && (out_col_q == w_eff - CW'(1));
						out_valid <= 1'b1;
						if ((out_row_q == h_eff - 17'd1) && (out_col_q == w_eff - CW'(1))) begin
							in_row_q <= '0; in_col_q <= '0; out_row_q <= '0; out_col_q <= '0;
							in_slot_q <= '0; out_slot_q <= '0;
						end else if (out_col_q + CW'(1) >= w_eff) begin
							out_col_q <= '0; out_row_q <= out_row_q + 17'd1;
							out_slot_q <= (out_slot_q == RW'(ROWS - 1)) ? '0 : out_slot_q + RW'(1);
						end else out_col_q <= out_col_q + CW'(1);
						st_q <= ST_IDLE;
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end
endmodule

### sv/mf2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_checker: port-level checks for the median filter
// Watches handshakes and configuration behavior from the ports.
// ----------------------------------------------------------------------------
module mf2d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] filtered_value,
	input logic        pready,
	input logic        psel,
	input logic        penable,
	input logic        pwrite
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered_value))
		else $error("stalled result changed");
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |-> in_stall)
		else $error("request taken during config write");
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !(in_valid && !in_stall))
		else $error("back-to-back requests taken");
endmodule

bind median_filter_2d_top mf2d_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .filtered_value(filtered_value),
	.pready(pready), .psel(psel), .penable(penable), .pwrite(pwrite));

### dv/tb_median_filter_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_2d_top: self-checking bench for the 2-D median filter
// A short table of directed requests covering edge cases, then random frames
// under random valid gaps and output stalls. Each accepted request advances
// a local model of the filter; every result is compared in order with it or a typed value.
// ----------------------------------------------------------------------------
module tb_median_filter_2d_top;

	localparam int LINE_MAX  = 1024;
	localparam int LINE_ROWS = 8;      // rows kept by the model's line store
	localparam int HOLD_LEN  = 400;    // long receiver hold-off, in cycles
	localparam int SETTLE    = 250;    // cycles to let an unseen request finish
	localparam int WDOG_MAX  = 4000;   // cycles with no transfer before timeout
	localparam int RAND_REQS = 950;

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} median_t;

	typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [31:0] val;
		logic        act;
		logic [15:0] pix;
		logic        has_exp;
		logic [15:0] exp_val;
		logic        exp_last;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = mf2d_pkg::ACT_PIXEL;
	logic [15:0] pixel_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] filtered_value;
	logic        frame_last;

	median_filter_2d_top DUT (.*);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Local filter model: line store, positions and register copies
	// ------------------------------------------------------------------
	logic [15:0] line_mem [LINE_ROWS*LINE_MAX];
	int unsigned pos_in_row, pos_in_col, pos_out_row, pos_out_col;
	logic [10:0] reg_w = 11'd640;
	logic [15:0] reg_h = 16'd480;
	logic [2:0]  reg_win = 3'd3;

	median_t     median_q[$];
	int          err_cnt = 0;
	bit          frame_done;
	bit          hold_req = 0;
	int          burst_left = 0;
	int          req_cnt = 0;

	function automatic logic [15:0] window_median(int unsigned w, int unsigned h,
			int unsigned b);
		int unsigned v[49];
		int unsigned n, r0, r1, c0, c1, x, j;
		n = 0;
		r0 = pos_out_row >= b ? pos_out_row - b : 0;
		r1 = pos_out_row + b < h ? pos_out_row + b : h - 1;
		c0 = pos_out_col >= b ? pos_out_col - b : 0;
		c1 = pos_out_col + b < w ? pos_out_col + b : w - 1;
		for (int unsigned r = r0; r <= r1; r++)
			for (int unsigned c = c0; c <= c1; c++) begin
				x = line_mem[(r % LINE_ROWS) * LINE_MAX + c];
				// insertion sort as the window is gathered
				j = n;
				while (j > 0 && v[j-1] > x) begin
					v[j] = v[j-1];
					j--;
				end
				v[j] = x;
				n++;
			end
		if (n[0])
			return 16'(v[n/2]);
		return 16'((v[n/2-1] + v[n/2]) / 2);
	endfunction

	// Advance the model by one request; return 1 when it yields a result.
	function automatic bit filter_step(input logic act, input logic [15:0] pix,
			output median_t res);
		int unsigned w, h, b, need_r, need_c;
		w = reg_w == 0 ? 1 : (reg_w > LINE_MAX ? LINE_MAX : reg_w);
		h = reg_h == 0 ? 1 : reg_h;
		b = reg_win == 0 ? 0 : (reg_win - 1) / 2;
		res = '0;
		if (act == mf2d_pkg::ACT_PIXEL && pos_in_row < h) begin
			line_mem[(pos_in_row % LINE_ROWS) * LINE_MAX + pos_in_col] = pix;
			pos_in_col++;
			if (pos_in_col >= w) begin
				pos_in_col = 0;
				pos_in_row++;
			end
		end
		if (pos_out_row >= h)
			return 0;
		need_r = pos_out_row + b < h ? pos_out_row + b : h - 1;
		need_c = pos_out_col + b < w ? pos_out_col + b : w - 1;
		if (!(pos_in_row > need_r || (pos_in_row == need_r && pos_in_col > need_c)))
			return 0;
		res.value = window_median(w, h, b);
		res.last = (pos_out_row == h - 1) && (pos_out_col == w - 1);
		if (res.last) begin
			pos_in_row = 0; pos_in_col = 0; pos_out_row = 0; pos_out_col = 0;
			frame_done = 1;
		end else begin
			pos_out_col++;
			if (pos_out_col >= w) begin
				pos_out_col = 0;
				pos_out_row++;
			end
		end
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// Register port and request driver
	// ------------------------------------------------------------------
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		// a drain that yields nothing may still be in the pipe
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			mf2d_pkg::REG_WIDTH:  reg_w = val[10:0];
			mf2d_pkg::REG_HEIGHT: reg_h = val[15:0];
			mf2d_pkg::REG_WINDOW: reg_win = val[2:0];
			default: ;
		endcase
		// a write to any of the three registers restarts the frame
		pos_in_row = 0; pos_in_col = 0; pos_out_row = 0; pos_out_col = 0;
	endtask

	// Offer one request, hold it until taken, then queue what it yields.
	task automatic send_req(input logic act, input logic [15:0] pix,
			input bit has_exp = 0, input median_t typed = '0);
		median_t res;
		bit      got;
		in_valid <= 1'b1;
		action <= act;
		pixel_value <= pix;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = filter_step(act, pix, res);
		if (has_exp)
			median_q.push_back(typed);
		else if (got)
			median_q.push_back(res);
		req_cnt++;
		// bursts of random length with idle gaps between them
		if (burst_left > 0)
			burst_left--;
		else begin
			int gap;
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 15);
		end
	endtask

	function automatic logic [15:0] rand_pix();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// Directed edge cases. Expected values are typed in only where obvious.
	dir_row_t dir_rows [36] = '{
		'{ROW_CFG, mf2d_pkg::REG_WIDTH,  32'd1, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_HEIGHT, 32'd1, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_WINDOW, 32'd1, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'h0000, 1'b1, 16'h0000, 1'b1},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
		// drain with nothing pending
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_DRAIN, 16'hA5A5, 1'b0, 16'h0,  1'b0},
		// zero width, height and window act as one
		'{ROW_CFG, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_HEIGHT, 32'd0, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_WINDOW, 32'd0, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'h1234, 1'b1, 16'h1234, 1'b1},
		// even count: floor average of the two middle samples
		'{ROW_CFG, mf2d_pkg::REG_WIDTH,  32'd2, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_HEIGHT, 32'd1, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_WINDOW, 32'd3, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd10,   1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd21,   1'b1, 16'd15, 1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_DRAIN, 16'h0,    1'b1, 16'd15, 1'b1},
		// even window size rounds down to the odd size below
		'{ROW_CFG, mf2d_pkg::REG_WIDTH,  32'd3, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_HEIGHT, 32'd2, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_WINDOW, 32'd2, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd7,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'h0000, 1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'hFFFF, 1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd3,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'h8000, 1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd1,    1'b0, 16'h0,  1'b0},
		// largest window over a tiny frame, then a pixel past the frame end
		'{ROW_CFG, mf2d_pkg::REG_WIDTH,  32'd2, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_HEIGHT, 32'd2, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_CFG, mf2d_pkg::REG_WINDOW, 32'd7, mf2d_pkg::ACT_PIXEL, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd100,  1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'h0000, 1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'hFFFF, 1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd50,   1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_PIXEL, 16'd9,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_DRAIN, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_DRAIN, 16'h0,    1'b0, 16'h0,  1'b0},
		'{ROW_REQ, mf2d_pkg::REG_WIDTH,  32'd0, mf2d_pkg::ACT_DRAIN, 16'h0,    1'b0, 16'h0,  1'b0}
	};

	initial begin
		int          phase;
		int          n_pix, limit, guard;
		logic [10:0] w_sel;
		logic [15:0] h_sel;
		bit          truncate;
		median_t     typed;

		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				typed = '{dir_rows[i].exp_val, dir_rows[i].exp_last};
				send_req(dir_rows[i].act, dir_rows[i].pix, dir_rows[i].has_exp, typed);
			end
		end

		// Random frames: mostly complete frames flushed by drains, some cut short.
		phase = 0;
		while (req_cnt < RAND_REQS) begin
			wait_drained();
			case ($urandom_range(0, 9))
				0: w_sel = 11'd0;
				1: w_sel = (phase % 2) ? 11'd1024 : 11'd2047;
				2: w_sel = $urandom_range(7, 12);
				default: w_sel = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 9))
				0: h_sel = 16'd0;
				1: h_sel = 16'hFFFF;
				2: h_sel = $urandom_range(6, 9);
				default: h_sel = $urandom_range(1, 5);
			endcase
			write_reg(mf2d_pkg::REG_WIDTH, {21'($urandom), w_sel});
			write_reg(mf2d_pkg::REG_HEIGHT, {16'($urandom), h_sel});
			write_reg(mf2d_pkg::REG_WINDOW, $urandom);

			n_pix = (w_sel == 0 ? 1 : (w_sel > 1024 ? 1024 : w_sel)) *
				(h_sel == 0 ? 1 : h_sel);
			truncate = ($urandom_range(0, 6) == 0) || n_pix > 120;
			limit = truncate ? $urandom_range(1, n_pix < 60 ? n_pix : 60) : n_pix;

			// long receiver hold-off so the block backs up into its input
			if (phase == 3)
				hold_req = 1;

			frame_done = 0;
			for (int k = 0; k < limit; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_req(mf2d_pkg::ACT_DRAIN, rand_pix());
				send_req(mf2d_pkg::ACT_PIXEL, rand_pix());
			end
			if (!truncate) begin
				guard = 0;
				while (!frame_done && guard < 200) begin
					// a pixel past the frame end acts as a drain
					send_req($urandom_range(0, 4) == 0 ? mf2d_pkg::ACT_PIXEL
						: mf2d_pkg::ACT_DRAIN, rand_pix());
					guard++;
				end
				send_req(mf2d_pkg::ACT_DRAIN, rand_pix());
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS median_filter_2d_top");
		else
			$display("FAIL median_filter_2d_top");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern that rotates through three modes, plus hold-off
	// ------------------------------------------------------------------
	int cyc = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else begin
			case ((cyc / 97) % 3)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				default: out_stall <= cyc[0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result check and watchdog
	// ------------------------------------------------------------------
	int idle_cyc = 0;
	always @(posedge clk) begin
		median_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (median_q.size() == 0) begin
					$error("unexpected result: filtered_value %h frame_last %b",
						filtered_value, frame_last);
					err_cnt++;
				end else begin
					want = median_q.pop_front();
					if (filtered_value !== want.value) begin
						$error("filtered_value: expected %h actual %h", want.value,
							filtered_value);
						err_cnt++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last: expected %b actual %b", want.last, frame_last);
						err_cnt++;
					end
				end
			end
			// count cycles with neither channel moving
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cyc <= 0;
			else if (idle_cyc >= WDOG_MAX) begin
				$display("FAIL median_filter_2d_top");
				$finish;
			end else
				idle_cyc <= idle_cyc + 1;
		end
	end

endmodule

### filelist.f
sv/mf2d_pkg.sv
sv/mf2d_cell.sv
sv/mf2d_sort.sv
sv/median_filter_2d_top.sv
sv/mf2d_checker.sv
dv/tb_median_filter_2d_top.sv
